/* sv/sgdmf_pkg.sv */
// ----------------------------------------------------------------------------
// sgdmf_pkg
// Shared item types, action codes and the controller/datapath link structs
// for the SGD matrix factorization update engine.
// ----------------------------------------------------------------------------
package sgdmf_pkg;

  localparam logic [2:0] ACT_WRITE_LEFT  = 3'd0;
  localparam logic [2:0] ACT_WRITE_RIGHT = 3'd1;
  localparam logic [2:0] ACT_SGD_UPDATE  = 3'd2;
  localparam logic [2:0] ACT_READ_LEFT   = 3'd3;
  localparam logic [2:0] ACT_READ_RIGHT  = 3'd4;

  localparam logic CFG_LEARN_RATE  = 1'b0;
  localparam logic CFG_RANK_IN_USE = 1'b1;

  localparam logic [15:0] LEARN_RATE_RESET  = 16'd655;
  localparam logic [5:0]  RANK_IN_USE_RESET = 6'd32;

  typedef struct packed {
    logic [2:0]         action;
    logic [9:0]         row_index;
    logic [9:0]         col_index;
    logic [4:0]         element_index;
    logic signed [15:0] factor_value;
    logic signed [15:0] rating;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] read_value;
    logic signed [31:0] prediction;
    logic [31:0]        squared_error;
    logic               overflow;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic load_base;
    logic start_pass;
    logic clear_acc;
    logic issue;
    logic mode_upd;
    logic write_single;
    logic calc_pred;
    logic calc_es;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic       issue_last;
    logic       pipe_busy;
  } status_t;

endpackage

/* sv/sgd_matrix_factorization_update.sv */
// ----------------------------------------------------------------------------
// sgd_matrix_factorization_update
// SGD matrix factorization engine: holds left and right factor matrices,
// writes and reads single entries, and runs one rating update per item.
// ----------------------------------------------------------------------------
//  Channel  | Handshake            | Payload
//  ---------+----------------------+--------------------------------
//  input    | in_valid / in_stall  | in_item  (in_item_t)
//  output   | out_valid / out_stall| out_item (out_item_t)
//  config   | cfg_write            | cfg_index, cfg_data
//
// An sgd item reads one factor pair per cycle through the single read port of
// each factor memory, once for the dot product and once for the update pass,
// and each pass drains the pipe before the next step.
// Reset is synchronous; it clears the control state and the configuration
// registers, not the factor memories. A result waits in the output register
// while the next item is taken; the engine stalls its input until it is idle.
// ----------------------------------------------------------------------------
module sgd_matrix_factorization_update #(
  parameter int ROWS        = 1024,
  parameter int COLS        = 1024,
  parameter int MAX_RANK    = 32,
  parameter int FACTOR_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sgdmf_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sgdmf_pkg::out_item_t out_item,
  input  logic                 cfg_write,
  input  logic                 cfg_index,
  input  logic [15:0]          cfg_data
);
  import sgdmf_pkg::*;

  cmd_t    cmd;
  status_t status;

  sgdmf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .cmd      (cmd)
  );

  sgdmf_datapath #(
    .ROWS       (ROWS),
    .COLS       (COLS),
    .MAX_RANK   (MAX_RANK),
    .FACTOR_BITS(FACTOR_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_item  (in_item),
    .cmd      (cmd),
    .status   (status),
    .out_item (out_item)
  );

endmodule

/* sv/sgdmf_ram.sv */
// ----------------------------------------------------------------------------
// sgdmf_ram
// Generic simple dual port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sgdmf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/sgdmf_ctrl.sv */
// ----------------------------------------------------------------------------
// sgdmf_ctrl
// Sequencer for the update engine: handshakes, action decode and the two
// passes (dot product, factor update) over the factor rows.
// ----------------------------------------------------------------------------
module sgdmf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  sgdmf_pkg::status_t status,
  output sgdmf_pkg::cmd_t    cmd
);
  import sgdmf_pkg::*;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_LOAD     = 4'd1;
  localparam logic [3:0] ST_WRITE    = 4'd2;
  localparam logic [3:0] ST_READ     = 4'd3;
  localparam logic [3:0] ST_DOT      = 4'd4;
  localparam logic [3:0] ST_DOT_WAIT = 4'd5;
  localparam logic [3:0] ST_PRED     = 4'd6;
  localparam logic [3:0] ST_ES       = 4'd7;
  localparam logic [3:0] ST_UPD      = 4'd8;
  localparam logic [3:0] ST_UPD_WAIT = 4'd9;
  localparam logic [3:0] ST_DONE     = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load_base  = 1'b1;
        cmd.start_pass = 1'b1;
        cmd.clear_acc  = 1'b1;
        case (status.action)
          ACT_WRITE_LEFT, ACT_WRITE_RIGHT: state_next = ST_WRITE;
          ACT_READ_LEFT, ACT_READ_RIGHT:   state_next = ST_READ;
          ACT_SGD_UPDATE:                  state_next = ST_DOT;
          default:                         state_next = ST_DONE;
        endcase
      end
      ST_WRITE: begin
        cmd.write_single = 1'b1;
        state_next       = ST_DONE;
      end
      ST_READ: begin
        state_next = ST_DONE;
      end
      ST_DOT: begin
        cmd.issue = 1'b1;
        if (status.issue_last) begin
          state_next = ST_DOT_WAIT;
        end
      end
      ST_DOT_WAIT: begin
        if (!status.pipe_busy) begin
          state_next = ST_PRED;
        end
      end
      ST_PRED: begin
        cmd.calc_pred  = 1'b1;
        cmd.start_pass = 1'b1;
        state_next     = ST_ES;
      end
      ST_ES: begin
        cmd.calc_es = 1'b1;
        state_next  = ST_UPD;
      end
      ST_UPD: begin
        cmd.issue    = 1'b1;
        cmd.mode_upd = 1'b1;
        if (status.issue_last) begin
          state_next = ST_UPD_WAIT;
        end
      end
      ST_UPD_WAIT: begin
        cmd.mode_upd = 1'b1;
        if (!status.pipe_busy) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* sv/sgdmf_datapath.sv */
// ----------------------------------------------------------------------------
// sgdmf_datapath
// Factor memories, configuration registers, the multiply-accumulate pipe for
// the prediction and the update pipe that rewrites both factor rows.
// ----------------------------------------------------------------------------
module sgdmf_datapath #(
  parameter int ROWS        = 1024,
  parameter int COLS        = 1024,
  parameter int MAX_RANK    = 32,
  parameter int FACTOR_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic                 cfg_index,
  input  logic [15:0]          cfg_data,
  input  sgdmf_pkg::in_item_t  in_item,
  input  sgdmf_pkg::cmd_t      cmd,
  output sgdmf_pkg::status_t   status,
  output sgdmf_pkg::out_item_t out_item
);
  import sgdmf_pkg::*;

  localparam int F   = FACTOR_BITS;
  localparam int LAW = $clog2(ROWS * MAX_RANK);
  localparam int RAW = $clog2(COLS * MAX_RANK);
  localparam int KW  = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam int PW  = 36 + F;
  localparam int ACW = (2 * F + 9 > 40) ? 2 * F + 9 : 40;
  localparam int RSH = 10 + $clog2(ROWS);
  localparam int CSH = 10 + $clog2(COLS);

  localparam logic [63:0] ROW_RCP = ((64'd1 << RSH) + 64'(ROWS) - 64'd1) / 64'(ROWS);
  localparam logic [63:0] COL_RCP = ((64'd1 << CSH) + 64'(COLS) - 64'd1) / 64'(COLS);

  localparam logic signed [PW-1:0]  HALF_P = PW'(2048);
  localparam logic signed [ACW-1:0] HALF_A = ACW'(2048);
  localparam logic signed [50:0]    HALF_E = 51'(32768);

  // Saturate a wide update sum to the factor width.
  function automatic logic [F-1:0] sat_val(input logic signed [PW:0] v);
    logic [PW-F+1:0] top;
    top = v[PW:F-1];
    if (top == '0 || top == '1) begin
      return v[F-1:0];
    end else if (v[PW]) begin
      return {1'b1, {(F-1){1'b0}}};
    end else begin
      return {1'b0, {(F-1){1'b1}}};
    end
  endfunction

  function automatic logic sat_ovf(input logic signed [PW:0] v);
    logic [PW-F+1:0] top;
    top = v[PW:F-1];
    return !(top == '0 || top == '1);
  endfunction

  logic [15:0]    learn_rate;
  logic [5:0]     rank_in_use;
  in_item_t       item_r;
  logic [LAW-1:0] row_base;
  logic [RAW-1:0] col_base;
  logic [KW-1:0]  k;
  logic [KW-1:0]  last_k;
  int             rank_int;
  logic [63:0]    row_prod;
  logic [63:0]    col_prod;
  logic [31:0]    row_mod;
  logic [31:0]    col_mod;
  logic           el_ok;
  logic [31:0]    rd_idx;

  logic           l_we;
  logic           r_we;
  logic [LAW-1:0] l_waddr;
  logic [RAW-1:0] r_waddr;
  logic [F-1:0]   l_wdata;
  logic [F-1:0]   r_wdata;
  logic [F-1:0]   l_dout;
  logic [F-1:0]   r_dout;
  logic signed [F-1:0] rd_l;
  logic signed [F-1:0] rd_r;

  // Pipe stages: s1 has memory data, s2 the first product, s3 the new left
  // entry, s4 the second product and the write back.
  logic          s1, s2, s3, s4;
  logic [KW-1:0] k1, k2, k3, k4;
  logic signed [2*F-1:0] prod;
  logic signed [ACW-1:0] acc;
  logic signed [PW-1:0]  p1;
  logic signed [PW-1:0]  p2;
  logic signed [PW-1:0]  p1_sh;
  logic signed [PW-1:0]  p2_sh;
  logic signed [PW:0]    nl_full;
  logic signed [PW:0]    nr_full;
  logic signed [PW:0]    wv_full;
  logic signed [F-1:0]   l1, r1, l2, r2, l3, r3;
  logic                  ovf;

  logic signed [ACW-1:0] pred_rnd;
  logic signed [31:0]    pred_r;
  logic signed [31:0]    pred_sat;
  logic signed [33:0]    err;
  logic signed [33:0]    err_r;
  logic signed [50:0]    es_prod;
  logic signed [50:0]    es_rnd;
  logic signed [35:0]    es2;
  logic [32:0]           mag;
  logic [65:0]           sq_full;
  logic [65:0]           sq_rnd;
  logic [31:0]           sq_r;
  out_item_t             out_next;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      learn_rate  <= LEARN_RATE_RESET;
      rank_in_use <= RANK_IN_USE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_LEARN_RATE:  learn_rate  <= cfg_data;
        CFG_RANK_IN_USE: rank_in_use <= cfg_data[5:0];
        default:         learn_rate  <= learn_rate;
      endcase
    end
  end

  always_comb begin
    if (rank_in_use == 6'd0) begin
      rank_int = 1;
    end else if (int'(rank_in_use) > MAX_RANK) begin
      rank_int = MAX_RANK;
    end else begin
      rank_int = int'(rank_in_use);
    end
    last_k = KW'(rank_int - 1);
  end

  // Index wrap through a rounded-up reciprocal of the bound, which gives the
  // exact quotient for every 10-bit index.
  always_comb begin
    row_prod = 64'(item_r.row_index) * ROW_RCP;
    col_prod = 64'(item_r.col_index) * COL_RCP;
    row_mod  = 32'(item_r.row_index) - 32'(row_prod >> RSH) * 32'(ROWS);
    col_mod  = 32'(item_r.col_index) - 32'(col_prod >> CSH) * 32'(COLS);
  end

  assign el_ok = (32'(item_r.element_index) < 32'(MAX_RANK));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_item;
    end
    if (cmd.load_base) begin
      row_base <= LAW'(row_mod * 32'(MAX_RANK));
      col_base <= RAW'(col_mod * 32'(MAX_RANK));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (cmd.start_pass) begin
      k <= '0;
    end else if (cmd.issue) begin
      k <= k + KW'(1);
    end
  end

  assign status.action     = item_r.action;
  assign status.issue_last = (k == last_k);
  assign status.pipe_busy  = s1 | s2 | s3 | s4;

  // Memories.
  assign rd_idx  = cmd.issue ? 32'(k) : 32'(item_r.element_index);
  assign wv_full = (PW+1)'(item_r.factor_value);

  always_comb begin
    l_we    = 1'b0;
    r_we    = 1'b0;
    l_waddr = row_base + LAW'(k4);
    r_waddr = col_base + RAW'(k4);
    l_wdata = l3;
    r_wdata = sat_val(nr_full);
    if (cmd.write_single) begin
      l_waddr = row_base + LAW'(item_r.element_index);
      r_waddr = col_base + RAW'(item_r.element_index);
      l_wdata = sat_val(wv_full);
      r_wdata = sat_val(wv_full);
      l_we    = el_ok && (item_r.action == ACT_WRITE_LEFT);
      r_we    = el_ok && (item_r.action == ACT_WRITE_RIGHT);
    end else if (s4 && cmd.mode_upd) begin
      l_we = 1'b1;
      r_we = 1'b1;
    end
  end

  sgdmf_ram #(
    .WIDTH(F),
    .DEPTH(ROWS * MAX_RANK)
  ) u_left_ram (
    .clk  (clk),
    .we   (l_we),
    .waddr(l_waddr),
    .wdata(l_wdata),
    .raddr(row_base + LAW'(rd_idx)),
    .rdata(l_dout)
  );

  sgdmf_ram #(
    .WIDTH(F),
    .DEPTH(COLS * MAX_RANK)
  ) u_right_ram (
    .clk  (clk),
    .we   (r_we),
    .waddr(r_waddr),
    .wdata(r_wdata),
    .raddr(col_base + RAW'(rd_idx)),
    .rdata(r_dout)
  );

  assign rd_l = l_dout;
  assign rd_r = r_dout;

  // Pipe arithmetic.
  assign p1_sh   = (p1 + HALF_P) >>> 12;
  assign nl_full = (PW+1)'(l1) + (PW+1)'(p1_sh);
  assign p2_sh   = (p2 + HALF_P) >>> 12;
  assign nr_full = (PW+1)'(r3) + (PW+1)'(p2_sh);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= 1'b0;
      s2 <= 1'b0;
      s3 <= 1'b0;
      s4 <= 1'b0;
    end else begin
      s1 <= cmd.issue;
      s2 <= s1;
      s3 <= s2;
      s4 <= s3;
    end
  end

  always_ff @(posedge clk) begin
    k1   <= k;
    k2   <= k1;
    k3   <= k2;
    k4   <= k3;
    prod <= (2*F)'(rd_l) * (2*F)'(rd_r);
    p1   <= PW'(es2) * PW'(rd_r);
    l1   <= rd_l;
    r1   <= rd_r;
    l2   <= sat_val(nl_full);
    r2   <= r1;
    p2   <= PW'(es2) * PW'(l2);
    l3   <= l2;
    r3   <= r2;
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_acc) begin
      acc <= '0;
      ovf <= 1'b0;
    end else begin
      if (s2 && !cmd.mode_upd) begin
        acc <= acc + ACW'(prod);
      end
      ovf <= ovf | (s2 && cmd.mode_upd && sat_ovf(nl_full))
                 | (s4 && cmd.mode_upd && sat_ovf(nr_full));
    end
  end

  // Prediction, error, scaled step and squared error.
  assign pred_rnd = (acc + HALF_A) >>> 12;

  always_comb begin
    if (pred_rnd[ACW-1:31] == '0 || pred_rnd[ACW-1:31] == '1) begin
      pred_sat = pred_rnd[31:0];
    end else if (pred_rnd[ACW-1]) begin
      pred_sat = 32'sh8000_0000;
    end else begin
      pred_sat = 32'sh7FFF_FFFF;
    end
  end

  assign err     = 34'(item_r.rating) - 34'(pred_sat);
  assign es_prod = 51'(err_r) * 51'($signed({1'b0, learn_rate}));
  assign es_rnd  = (es_prod + HALF_E) >>> 16;
  assign mag     = err_r[33] ? 33'(-err_r) : 33'(err_r);
  assign sq_full = 66'(mag) * 66'(mag);
  assign sq_rnd  = (sq_full + 66'd2048) >> 12;

  always_ff @(posedge clk) begin
    if (cmd.calc_pred) begin
      pred_r <= pred_sat;
      err_r  <= err;
    end
    if (cmd.calc_es) begin
      es2  <= {es_rnd[34:0], 1'b0};
      sq_r <= (|sq_rnd[65:32]) ? 32'hFFFF_FFFF : sq_rnd[31:0];
    end
  end

  // Result register.
  always_comb begin
    out_next = '0;
    case (item_r.action)
      ACT_READ_LEFT: begin
        if (el_ok) begin
          out_next.read_value = 16'(rd_l);
        end
      end
      ACT_READ_RIGHT: begin
        if (el_ok) begin
          out_next.read_value = 16'(rd_r);
        end
      end
      ACT_SGD_UPDATE: begin
        out_next.prediction    = pred_r;
        out_next.squared_error = sq_r;
        out_next.overflow      = ovf;
      end
      default: begin
        out_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_item <= out_next;
    end
  end

endmodule

/* dv/sgd_matrix_factorization_update_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sgd_matrix_factorization_update_tb
// Self-checking regression for the SGD matrix factorization engine. A
// scoreboard keeps its own copy of both factor matrices and the step and rank
// registers, predicts the result of every accepted item, and compares it with
// the result leaving the block. Directed corner items come first, then random
// write, read, update and unknown items over several register settings, with
// random idling and stalling on both channels.
// ----------------------------------------------------------------------------
module sgd_matrix_factorization_update_tb;
  import sgdmf_pkg::*;

  localparam int RANK_MAX   = 32;
  localparam int CYCLE_CAP  = 1000000;
  localparam int DRAIN_WAIT = 100;

  class rating_scoreboard;
    logic signed [15:0] left_mem[0:32767];
    logic signed [15:0] right_mem[0:32767];
    int unsigned step_q16;
    int unsigned rank_reg;
    out_item_t   awaited[$];
    int          errors;
    int          results_seen;

    function new();
      step_q16 = 32'(LEARN_RATE_RESET);
      rank_reg = 32'(RANK_IN_USE_RESET);
      errors = 0;
      results_seen = 0;
    endfunction

    function int eff_rank();
      if (rank_reg == 0) return 1;
      if (rank_reg > RANK_MAX) return RANK_MAX;
      return int'(rank_reg);
    endfunction

    function longint round_q(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function longint clamp_factor(longint v, inout bit ovf);
      if (v > 32767) begin
        ovf = 1;
        return 32767;
      end
      if (v < -32768) begin
        ovf = 1;
        return -32768;
      end
      return v;
    endfunction

    function void note_input(in_item_t it);
      out_item_t e;
      longint acc, pred, err, es, nl, nr;
      longint unsigned mag, sq;
      int lb, rb, rk;
      bit ovf;
      e = '0;
      ovf = 0;
      acc = 0;
      lb = it.row_index * RANK_MAX;
      rb = it.col_index * RANK_MAX;
      case (it.action)
        ACT_WRITE_LEFT:  left_mem[lb + it.element_index] = it.factor_value;
        ACT_WRITE_RIGHT: right_mem[rb + it.element_index] = it.factor_value;
        ACT_READ_LEFT:   e.read_value = left_mem[lb + it.element_index];
        ACT_READ_RIGHT:  e.read_value = right_mem[rb + it.element_index];
        ACT_SGD_UPDATE: begin
          rk = eff_rank();
          for (int k = 0; k < rk; k++)
            acc += longint'(left_mem[lb + k]) * longint'(right_mem[rb + k]);
          pred = round_q(acc, 12);
          if (pred > 64'sd2147483647) pred = 64'sd2147483647;
          if (pred < -64'sd2147483648) pred = -64'sd2147483648;
          err = longint'(it.rating) - pred;
          es = round_q(err * longint'(step_q16), 16);
          for (int k = 0; k < rk; k++) begin
            nl = longint'(left_mem[lb + k]) + round_q(2 * es * longint'(right_mem[rb + k]), 12);
            left_mem[lb + k] = 16'(clamp_factor(nl, ovf));
            nr = longint'(right_mem[rb + k]) + round_q(2 * es * longint'(left_mem[lb + k]), 12);
            right_mem[rb + k] = 16'(clamp_factor(nr, ovf));
          end
          mag = (err < 0) ? longint'(-err) : longint'(err);
          sq = (mag * mag + 64'd2048) >> 12;
          if (sq > 64'hFFFF_FFFF) sq = 64'hFFFF_FFFF;
          e.prediction = pred[31:0];
          e.squared_error = sq[31:0];
          e.overflow = ovf;
        end
        default: ;
      endcase
      awaited.insert(awaited.size(), e);
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      results_seen++;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: %p", $time, got);
        return;
      end
      e = awaited.pop_front();
      if (got.read_value !== e.read_value) begin
        errors++;
        $display("%0t: read_value expected %0d actual %0d", $time, e.read_value,
                 got.read_value);
      end
      if (got.prediction !== e.prediction) begin
        errors++;
        $display("%0t: prediction expected %0d actual %0d", $time, e.prediction,
                 got.prediction);
      end
      if (got.squared_error !== e.squared_error) begin
        errors++;
        $display("%0t: squared_error expected %0d actual %0d", $time, e.squared_error,
                 got.squared_error);
      end
      if (got.overflow !== e.overflow) begin
        errors++;
        $display("%0t: overflow expected %0b actual %0b", $time, e.overflow, got.overflow);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;
  logic        cfg_write;
  logic        cfg_index;
  logic [15:0] cfg_data;

  rating_scoreboard sb;
  int  send_idle;
  int  recv_idle;
  int  hold_off;
  int  cycles;
  int  items_sent;
  int  updates_sent;
  bit  left_written[0:32767];
  bit  right_written[0:32767];
  int  row_pool[6];
  int  col_pool[6];

  sgd_matrix_factorization_update dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Receiver side: a long hold-off overrides the random stalling.
  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_stall = 1'b1;
      hold_off--;
    end else begin
      out_stall = ($urandom_range(0, 99) < recv_idle);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (!rst && out_valid && !out_stall) sb.check_result(out_item);
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("sgd_matrix_factorization_update regression: fail");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(in_item_t it);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_item = it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    items_sent++;
    if (it.action == ACT_SGD_UPDATE) updates_sent++;
    if (it.action == ACT_WRITE_LEFT)
      left_written[it.row_index * RANK_MAX + it.element_index] = 1;
    if (it.action == ACT_WRITE_RIGHT)
      right_written[it.col_index * RANK_MAX + it.element_index] = 1;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_write = 1'b0;
    if (idx == CFG_LEARN_RATE) sb.step_q16 = 32'(val);
    else sb.rank_reg = 32'(val[5:0]);
  endtask

  // Wait for every result, then leave the block idle for a while.
  task automatic drain();
    while (sb.awaited.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  function automatic in_item_t make_item(logic [2:0] act, int row, int col, int el,
                                         int val, int rat);
    in_item_t it;
    it.action = act;
    it.row_index = 10'(row);
    it.col_index = 10'(col);
    it.element_index = 5'(el);
    it.factor_value = 16'(val);
    it.rating = 16'(rat);
    return it;
  endfunction

  function automatic logic [15:0] pick_q412();
    if ($urandom_range(0, 9) < 8) return 16'($urandom_range(0, 8191) - 4096);
    return 16'($urandom);
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int row, col, r, lb, rb, missing_l, missing_r;
    it = in_item_t'(60'({$urandom, $urandom}));
    row = row_pool[$urandom_range(0, 5)];
    col = col_pool[$urandom_range(0, 5)];
    it.row_index = 10'(row);
    it.col_index = 10'(col);
    it.factor_value = pick_q412();
    if ($urandom_range(0, 9) < 7) it.rating = 16'($urandom_range(0, 16383) - 8192);
    lb = row * RANK_MAX;
    rb = col * RANK_MAX;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      it.action = 3'($urandom_range(5, 7));
    end else if (r < 55) begin
      // An update may only touch written entries, so fill gaps first.
      missing_l = -1;
      missing_r = -1;
      for (int k = sb.eff_rank() - 1; k >= 0; k--) begin
        if (!left_written[lb + k]) missing_l = k;
        if (!right_written[rb + k]) missing_r = k;
      end
      if (missing_l >= 0) begin
        it.action = ACT_WRITE_LEFT;
        it.element_index = 5'(missing_l);
      end else if (missing_r >= 0) begin
        it.action = ACT_WRITE_RIGHT;
        it.element_index = 5'(missing_r);
      end else begin
        it.action = ACT_SGD_UPDATE;
      end
    end else if (r < 75) begin
      it.action = $urandom_range(0, 1) ? ACT_WRITE_RIGHT : ACT_WRITE_LEFT;
    end else if ($urandom_range(0, 1)) begin
      it.action = left_written[lb + it.element_index] ? ACT_READ_LEFT : ACT_WRITE_LEFT;
    end else begin
      it.action = right_written[rb + it.element_index] ? ACT_READ_RIGHT : ACT_WRITE_RIGHT;
    end
    return it;
  endfunction

  task automatic run_phase(int count, logic [15:0] step, logic [15:0] rank, int s_idle,
                           int r_idle, int hold);
    drain();
    write_reg(CFG_LEARN_RATE, step);
    write_reg(CFG_RANK_IN_USE, rank);
    send_idle = s_idle;
    recv_idle = r_idle;
    hold_off = hold;
    repeat (count) send_item(random_item());
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    cfg_write = 1'b0;
    cfg_index = CFG_LEARN_RATE;
    cfg_data = '0;
    send_idle = 36;
    recv_idle = 83;
    hold_off = 0;
    cycles = 0;
    items_sent = 0;
    updates_sent = 0;
    row_pool = '{0, 1023, 341, 682, 0, 0};
    col_pool = '{0, 1023, 682, 341, 0, 0};
    for (int i = 4; i < 6; i++) begin
      row_pool[i] = $urandom_range(1, 1022);
      col_pool[i] = $urandom_range(1, 1022);
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed corners with a single latent position in use.
    write_reg(CFG_RANK_IN_USE, 16'd1);
    send_item(make_item(ACT_WRITE_LEFT, 0, 0, 0, 32767, 0));
    send_item(make_item(ACT_WRITE_RIGHT, 0, 0, 0, 32767, 0));
    send_item(make_item(ACT_SGD_UPDATE, 0, 0, 0, 0, -32768));
    send_item(make_item(ACT_READ_LEFT, 0, 0, 0, 0, 0));
    send_item(make_item(ACT_READ_RIGHT, 0, 0, 0, 0, 0));
    send_item(make_item(ACT_WRITE_LEFT, 0, 0, 0, -32768, 0));
    send_item(make_item(ACT_WRITE_RIGHT, 0, 0, 0, -32768, 0));
    send_item(make_item(ACT_SGD_UPDATE, 0, 0, 0, 0, 32767));
    send_item(make_item(ACT_WRITE_LEFT, 0, 0, 0, 0, 0));
    send_item(make_item(ACT_SGD_UPDATE, 0, 0, 0, 0, 0));
    send_item(make_item(ACT_WRITE_LEFT, 1023, 1023, 31, 32767, 0));
    send_item(make_item(ACT_WRITE_RIGHT, 1023, 1023, 31, -32768, 0));
    send_item(make_item(ACT_READ_LEFT, 1023, 1023, 31, 0, 0));
    send_item(make_item(ACT_READ_RIGHT, 1023, 1023, 31, 0, 0));
    send_item(make_item(3'd5, 1023, 1023, 31, -1, -1));
    send_item(make_item(3'd6, 0, 0, 0, 0, 0));
    send_item(make_item(3'd7, 341, 682, 21, 21845, -21846));

    run_phase(250, LEARN_RATE_RESET, 16'd1, 36, 83, 0);
    run_phase(250, 16'hFFFF, 16'd32, 36, 83, 2000);
    run_phase(250, 16'd0, 16'd0, 83, 36, 0);
    run_phase(250, 16'($urandom), 16'd63, 83, 36, 0);
    run_phase(250, 16'($urandom), 16'($urandom_range(1, 32)), 0, 0, 0);
    run_phase(250, 16'd1, 16'($urandom_range(1, 32)), 0, 0, 0);
    drain();

    $display("Sent %0d items (%0d rating updates), checked %0d results.", items_sent,
             updates_sent, sb.results_seen);
    $display("Covered step sizes 0 to max and ranks 0, 1, 32 and above maximum.");
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("sgd_matrix_factorization_update regression: pass");
    end else begin
      $display("sgd_matrix_factorization_update regression: fail");
    end
    $finish;
  end
endmodule
